FILE: hdl/ras_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Responsive analog smoother package
// Shared widths, fixed-point constants and register indexes for the smoother
// core and its snap gain divider.
// ----------------------------------------------------------------------------
package ras_pkg;

    // Sample range and fixed-point format of the state.
    localparam int RES       = 1024;
    localparam int FRAC      = 8;
    localparam int SMP_W     = $clog2(RES);
    localparam int TDATA_W   = ((SMP_W + 7) / 8) * 8;

    // Edge-adjusted sample, signed, spans about -RES .. 2*RES.
    localparam int V_W       = SMP_W + 2;
    localparam int ACC_W     = SMP_W + FRAC;
    localparam int ERR_W     = SMP_W + FRAC + 3;
    localparam int DIFF_W    = SMP_W + 1;

    // Error average gain 0.4 as 102/256, rounded half up.
    localparam int EMA_GAIN  = 102;
    localparam int EMA_SHIFT = 8;
    localparam int EMA_HALF  = 1 << (EMA_SHIFT - 1);
    localparam int EMA_W     = ERR_W + 1 + EMA_SHIFT + 1;

    // Snap multiplier in Q1.8, snap gain in Q1.16.
    localparam int MULT_W    = 9;
    localparam int MULT_ONE  = 256;
    localparam int X_W       = DIFF_W + MULT_W;
    localparam int SNAP_FRAC = 16;
    localparam int SNAP_W    = SNAP_FRAC + 1;
    localparam int SNAP_ONE  = 1 << SNAP_FRAC;
    localparam int SNAP_HALF = 1 << (SNAP_FRAC - 1);
    localparam int PROD_W    = ERR_W + SNAP_W + 1;
    localparam int STEP_W    = PROD_W - SNAP_FRAC;

    // Divider operand: only x below MULT_ONE needs a divide.
    localparam int DIV_X_W   = $clog2(MULT_ONE);
    localparam int DIV_D_W   = DIV_X_W + 1;
    localparam int DIV_CNT_W = $clog2(SNAP_FRAC + 1);

    localparam int MAX_ACC   = (RES - 1) << FRAC;

    // Configuration port.
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    typedef enum logic [1:0] {
        REG_SLEEP_EN  = 2'd0,
        REG_EDGE_EN   = 2'd1,
        REG_SNAP_MULT = 2'd2,
        REG_ACT_THR   = 2'd3
    } t_reg_idx;

endpackage

FILE: hdl/ras_snap_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snap gain divider
// Restoring divider computing floor(2*x*2^16 / (x + 256)) for x below 256,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ras_snap_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ras_pkg::DIV_X_W-1:0]   i_x,
    output logic                          o_busy,
    output logic [ras_pkg::SNAP_FRAC-1:0] o_quot
);
    import ras_pkg::*;

    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_dvs;
    logic [SNAP_FRAC-1:0] r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [DIV_D_W:0]     rem_shift;
    logic                 fits;

    // One restoring step: shift in a zero bit and try the subtract.
    assign rem_shift = {r_rem, 1'b0};
    assign fits      = rem_shift >= {1'b0, r_dvs};

    // The numerator's bits above the quotient are 2x, already below the
    // divisor, so they seed the remainder directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_rem  <= {i_x, 1'b0};
            r_dvs  <= DIV_D_W'(MULT_ONE) + DIV_D_W'(i_x);
            r_quot <= '0;
            r_cnt  <= DIV_CNT_W'(SNAP_FRAC);
        end else if (r_cnt != '0) begin
            r_rem  <= fits ? DIV_D_W'(rem_shift - {1'b0, r_dvs}) : DIV_D_W'(rem_shift);
            r_quot <= {r_quot[SNAP_FRAC-2:0], fits};
            r_cnt  <= r_cnt - DIV_CNT_W'(1);
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quot;

    // The partial remainder always stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_rem < r_dvs))
        else $error("divider remainder reached the divisor");

    // A new divide is never started over a running one.
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_cnt == '0))
        else $error("divider started while busy");

    // The step counter never exceeds one step per quotient bit.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DIV_CNT_W'(SNAP_FRAC))
        else $error("divider step counter out of range");

endmodule

FILE: hdl/responsive_analog_smoother_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Responsive analog smoother core
// Smooths 10-bit ADC samples with an adaptive snap gain, optional sleep on
// low error activity and optional edge snapping near the range ends.
// ----------------------------------------------------------------------------
// One sample item is taken at a time. An item that sleeps goes from the sleep
// decision straight to the output step, an item whose snap gain saturates skips
// the divide, and any other item waits for the restoring divide of the snap
// gain and then takes its quotient. The result sits in an output register, so
// the next sample is accepted while a result waits; a finished item waits only
// if the previous result has still not been taken. The user must write the
// configuration registers through the APB port only while the block is idle;
// the block itself does not enforce this.
module responsive_analog_smoother_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Sample input; tdata: raw_sample
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [ras_pkg::TDATA_W-1:0]    i_s_axis_tdata,
    // Result output; tdata: smoothed_value; tuser: value_changed, is_sleeping
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [ras_pkg::TDATA_W-1:0]    o_m_axis_tdata,
    output logic [1:0]                     o_m_axis_tuser,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ras_pkg::PADDR_W-1:0]    paddr,
    input  logic [ras_pkg::PDATA_W-1:0]    pwdata,
    output logic [ras_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import ras_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADJ,
        S_EMA,
        S_SLEEP,
        S_DIV,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    localparam logic signed [V_W-1:0] RES_S = V_W'(RES);

    // Configuration registers.
    logic               r_sleep_en;
    logic               r_edge_en;
    logic [MULT_W-1:0]  r_mult;
    logic [SMP_W-1:0]   r_thr;

    // Filter state and per-item working registers.
    t_state                    r_state;
    logic [ACC_W-1:0]          r_acc;
    logic signed [ERR_W-1:0]   r_err;
    logic [SMP_W-1:0]          r_last;
    logic [SMP_W-1:0]          r_raw;
    logic signed [ERR_W-1:0]   r_d;
    logic [DIFF_W-1:0]         r_diff;
    logic [X_W-1:0]            r_x;
    logic [SNAP_W-1:0]         r_snap;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_held;

    // Output register.
    logic               r_o_valid;
    logic [SMP_W-1:0]   r_o_value;
    logic               r_o_changed;
    logic               r_o_sleeping;

    logic                      in_fire;
    logic                      cfg_wr;
    logic [MULT_W-1:0]         mult_sat;
    logic signed [V_W-1:0]     v_in;
    logic signed [V_W-1:0]     thr_s;
    logic signed [V_W-1:0]     v_adj;
    logic signed [V_W-1:0]     acc_int;
    logic signed [V_W-1:0]     diff_s;
    logic signed [V_W-1:0]     diff_abs;
    logic signed [ERR_W-1:0]   d_new;
    logic signed [ERR_W:0]     ema_delta;
    logic signed [EMA_W-1:0]   ema_prod;
    logic signed [ERR_W-1:0]   err_new;
    logic [X_W-1:0]            x_new;
    logic [ERR_W-1:0]          err_abs;
    logic [ERR_W-1:0]          thr_fix;
    logic                      held;
    logic                      x_sat;
    logic                      div_start;
    logic                      div_busy;
    logic [SNAP_FRAC-1:0]      div_quot;
    logic signed [PROD_W-1:0]  snap_prod;
    logic signed [STEP_W-1:0]  acc_sum;
    logic [ACC_W-1:0]          acc_new;
    logic                      out_free;
    logic                      out_load;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_o_valid || i_m_axis_tready;
    assign out_load = (r_state == S_OUT) && out_free;

    // Multiplier writes whose low nine bits exceed 1.0 saturate to 1.0.
    assign mult_sat = (pwdata[MULT_W-1:0] > MULT_W'(MULT_ONE)) ?
                      MULT_W'(MULT_ONE) : pwdata[MULT_W-1:0];

    // Edge band adjustment, distance to the smoothed value and residual.
    always_comb begin
        v_in  = $signed(V_W'(r_raw));
        thr_s = $signed(V_W'(r_thr));
        v_adj = v_in;
        if (r_sleep_en && r_edge_en) begin
            if (v_in < thr_s) begin
                v_adj = (v_in <<< 1) - thr_s;
            end else if (v_in > RES_S - thr_s) begin
                v_adj = (v_in <<< 1) - RES_S + thr_s;
            end
        end
        acc_int  = $signed(V_W'(r_acc[ACC_W-1:FRAC]));
        diff_s   = v_adj - acc_int;
        diff_abs = diff_s[V_W-1] ? -diff_s : diff_s;
        d_new    = ($signed(ERR_W'(v_adj)) <<< FRAC) - $signed(ERR_W'(r_acc));
    end

    // Error average update and snap curve argument.
    always_comb begin
        ema_delta = $signed((ERR_W+1)'(r_d)) - $signed((ERR_W+1)'(r_err));
        ema_prod  = $signed(EMA_W'(ema_delta)) * $signed(EMA_W'(EMA_GAIN))
                    + $signed(EMA_W'(EMA_HALF));
        err_new   = r_err + ERR_W'(ema_prod >>> EMA_SHIFT);
        x_new     = X_W'(r_diff) * X_W'(r_mult);
    end

    // Sleep decision on the updated error average.
    always_comb begin
        err_abs   = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
        thr_fix   = ERR_W'({r_thr, FRAC'(0)});
        held      = r_sleep_en && (err_abs < thr_fix);
        x_sat     = r_x >= X_W'(MULT_ONE);
        div_start = (r_state == S_SLEEP) && !held && !x_sat;
    end

    // Apply the snap step and clamp to the valid range.
    always_comb begin
        snap_prod = $signed(PROD_W'(r_d)) * $signed(PROD_W'(r_snap))
                    + $signed(PROD_W'(SNAP_HALF));
        acc_sum   = $signed(STEP_W'(r_acc)) + STEP_W'(r_prod >>> SNAP_FRAC);
        if (acc_sum < 0) begin
            acc_new = '0;
        end else if (acc_sum > $signed(STEP_W'(MAX_ACC))) begin
            acc_new = ACC_W'(MAX_ACC);
        end else begin
            acc_new = ACC_W'(acc_sum);
        end
    end

    ras_snap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_x     (r_x[DIV_X_W-1:0]),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep_en <= 1'b0;
            r_edge_en  <= 1'b1;
            r_mult     <= MULT_W'(3);
            r_thr      <= SMP_W'(4);
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[PADDR_W-1:2]))
                REG_SLEEP_EN:  r_sleep_en <= pwdata[0];
                REG_EDGE_EN:   r_edge_en  <= pwdata[0];
                REG_SNAP_MULT: r_mult     <= mult_sat;
                REG_ACT_THR:   r_thr      <= pwdata[SMP_W-1:0];
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (t_reg_idx'(paddr[PADDR_W-1:2]))
            REG_SLEEP_EN:  prdata = PDATA_W'(r_sleep_en);
            REG_EDGE_EN:   prdata = PDATA_W'(r_edge_en);
            REG_SNAP_MULT: prdata = PDATA_W'(r_mult);
            REG_ACT_THR:   prdata = PDATA_W'(r_thr);
        endcase
    end

    assign pready = 1'b1;

    // Item sequencer, filter state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acc     <= '0;
            r_err     <= '0;
            r_last    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // A result is loaded by the output step and kept until it is taken.
            r_o_valid <= out_load || (r_o_valid && !i_m_axis_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_raw   <= i_s_axis_tdata[SMP_W-1:0];
                        r_state <= S_ADJ;
                    end
                end
                S_ADJ: begin
                    r_d     <= d_new;
                    r_diff  <= DIFF_W'(diff_abs);
                    r_state <= S_EMA;
                end
                S_EMA: begin
                    r_err   <= err_new;
                    r_x     <= x_new;
                    r_state <= S_SLEEP;
                end
                S_SLEEP: begin
                    r_held <= held;
                    if (held) begin
                        r_state <= S_OUT;
                    end else if (x_sat) begin
                        r_snap  <= SNAP_W'(SNAP_ONE);
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!div_busy) begin
                        r_snap  <= SNAP_W'(div_quot);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= snap_prod;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= acc_new;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_value    <= r_acc[ACC_W-1:FRAC];
                        r_o_changed  <= r_acc[ACC_W-1:FRAC] != r_last;
                        r_o_sleeping <= r_held;
                        r_last       <= r_acc[ACC_W-1:FRAC];
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = TDATA_W'(r_o_value);
    assign o_m_axis_tuser  = {r_o_sleeping, r_o_changed};

    // Only one item is in flight: acceptance drops ready for the next cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_s_axis_tready)
        else $error("second item accepted while one is in flight");

    // The smoothed accumulator never leaves the clamped range.
    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= ACC_W'(MAX_ACC))
        else $error("smoothed accumulator out of range");

    // A held item can only come from an enabled sleep mode.
    a_held_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_held) |-> r_sleep_en)
        else $error("item held with sleep disabled");

    // A new result appears only when an item finishes.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_OUT))
        else $error("result issued outside the output step");

endmodule
